>>> src/srrw_pkg.sv
`timescale 1ns / 1ps

package srrw_pkg;

    localparam int SEQ_W      = 7;
    localparam int CTL_W      = 8;
    localparam int LEN_W      = 6;
    localparam int MAX_WINDOW = 32;
    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_WINDOW);

    typedef logic [MAX_WINDOW-1:0] marks_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [CTL_W-1:0] ctl;
    } pkt_t;

endpackage

>>> src/srrw_front.sv
`timescale 1ns / 1ps

module srrw_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [srrw_pkg::SEQ_W-1:0] s_seq_num,
    input  logic [srrw_pkg::CTL_W-1:0] s_control,
    input  logic                      s_intact,
    output srrw_pkg::pkt_t            q_pkt,
    output logic                      q_valid,
    input  logic                      q_pop
);

    srrw_pkg::pkt_t                    queue_reg [srrw_pkg::QUEUE_DEPTH];
    logic [srrw_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [srrw_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [srrw_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                             push;
    logic                             pop;

    // Damaged requests are taken and dropped here; they never reach the window.
    assign s_ready = (count_reg != srrw_pkg::QCNT_W'(srrw_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready && s_intact;
    assign pop     = q_pop && (count_reg != '0);

    assign q_pkt   = queue_reg[rd_ptr_reg];
    assign q_valid = (count_reg != '0);

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= '{seq: s_seq_num, ctl: s_control};
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= srrw_pkg::QCNT_W'(srrw_pkg::QUEUE_DEPTH))
        else $error("queue count exceeds its depth");

endmodule

>>> src/srrw_back.sv
`timescale 1ns / 1ps

module srrw_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [srrw_pkg::LEN_W-1:0]  cfg_wr_data,
    input  srrw_pkg::pkt_t              q_pkt,
    input  logic                        q_valid,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [srrw_pkg::SEQ_W-1:0]  m_ack_seq,
    output logic [srrw_pkg::CTL_W-1:0]  m_ack_control,
    output logic [srrw_pkg::LEN_W-1:0]  m_released
);

    logic [srrw_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [srrw_pkg::SEQ_W-1:0]  base_reg, base_next;
    srrw_pkg::marks_t            marks_reg, marks_next;
    logic [srrw_pkg::CTL_W-1:0]  flags_reg [srrw_pkg::MAX_WINDOW];
    logic                        out_valid_reg, out_valid_next;
    logic [srrw_pkg::SEQ_W-1:0]  ack_seq_reg;
    logic [srrw_pkg::CTL_W-1:0]  ack_ctl_reg;
    logic [srrw_pkg::LEN_W-1:0]  released_reg;

    logic [srrw_pkg::LEN_W-1:0]  cfg_len;
    srrw_pkg::marks_t            cfg_mask;
    srrw_pkg::marks_t            len_mask;
    logic [srrw_pkg::SEQ_W-1:0]  off;
    logic                        in_win;
    logic                        fresh;
    srrw_pkg::marks_t            marks_set;
    logic [srrw_pkg::LEN_W-1:0]  run;
    logic [srrw_pkg::SEQ_W-1:0]  last_seq;
    logic                        ctl_bypass;
    logic                        emit;

    always_comb begin
        cfg_len = cfg_wr_data;
        if (cfg_wr_data == '0) begin
            cfg_len = srrw_pkg::LEN_W'(1);
        end else if (cfg_wr_data > srrw_pkg::LEN_W'(srrw_pkg::MAX_WINDOW)) begin
            cfg_len = srrw_pkg::LEN_W'(srrw_pkg::MAX_WINDOW);
        end
    end

    assign cfg_mask = srrw_pkg::MAX_WINDOW'(
        ((srrw_pkg::MAX_WINDOW+1)'(1) << cfg_len) - (srrw_pkg::MAX_WINDOW+1)'(1));
    assign len_mask = srrw_pkg::MAX_WINDOW'(
        ((srrw_pkg::MAX_WINDOW+1)'(1) << len_reg) - (srrw_pkg::MAX_WINDOW+1)'(1));

    assign q_pop = q_valid && (!out_valid_reg || m_ready);

    // Flags live at the low bits of the absolute number, so the store never shifts.
    always_comb begin
        off       = q_pkt.seq - base_reg;
        in_win    = (off < srrw_pkg::SEQ_W'(len_reg));
        fresh     = in_win && !marks_reg[off[srrw_pkg::SLOT_W-1:0]];
        marks_set = marks_reg;
        if (in_win) begin
            marks_set[off[srrw_pkg::SLOT_W-1:0]] = 1'b1;
        end
        run = srrw_pkg::LEN_W'(srrw_pkg::MAX_WINDOW);
        for (int i = srrw_pkg::MAX_WINDOW - 1; i >= 0; i--) begin
            if (!marks_set[i]) begin
                run = srrw_pkg::LEN_W'(i);
            end
        end
        last_seq   = base_reg + srrw_pkg::SEQ_W'(run) - srrw_pkg::SEQ_W'(1);
        ctl_bypass = fresh && (q_pkt.seq[srrw_pkg::SLOT_W-1:0] ==
                               last_seq[srrw_pkg::SLOT_W-1:0]);
        emit       = q_pop && marks_set[0];
    end

    always_comb begin
        len_next       = len_reg;
        base_next      = base_reg;
        marks_next     = marks_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (cfg_wr_en) begin
            len_next   = cfg_len;
            marks_next = marks_reg & cfg_mask;
        end else if (q_pop) begin
            if (marks_set[0]) begin
                marks_next     = marks_set >> run;
                base_next      = base_reg + srrw_pkg::SEQ_W'(run);
                out_valid_next = 1'b1;
            end else begin
                marks_next = marks_set;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= srrw_pkg::LEN_RESET;
            base_reg      <= '0;
            marks_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            len_reg       <= len_next;
            base_reg      <= base_next;
            marks_reg     <= marks_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && !cfg_wr_en && fresh) begin
            flags_reg[q_pkt.seq[srrw_pkg::SLOT_W-1:0]] <= q_pkt.ctl;
        end
        if (emit && !cfg_wr_en) begin
            ack_seq_reg  <= last_seq;
            released_reg <= run;
            if (ctl_bypass) begin
                ack_ctl_reg <= q_pkt.ctl;
            end else begin
                ack_ctl_reg <= flags_reg[last_seq[srrw_pkg::SLOT_W-1:0]];
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_ack_seq     = ack_seq_reg;
    assign m_ack_control = ack_ctl_reg;
    assign m_released    = released_reg;

    a_base_slot_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !marks_reg[0])
        else $error("base slot left marked after a step");

    a_marks_in_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (marks_reg & ~len_mask) == '0)
        else $error("mark set beyond the window length");

    a_released_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_released != '0) &&
                    (m_released <= srrw_pkg::LEN_W'(srrw_pkg::MAX_WINDOW)))
        else $error("released count out of range");

    a_base_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !cfg_wr_en) |=> (base_reg == m_ack_seq + srrw_pkg::SEQ_W'(1)))
        else $error("window base does not follow the acknowledged number");

endmodule

>>> src/selective_repeat_receive_window.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_seq_num, s_control, s_intact
// m_        out        m_valid / m_ready  m_ack_seq, m_ack_control, m_released
// cfg_      in         cfg_wr_en          cfg_wr_data (window length)
//
// One request per cycle is sustained while the m_ side keeps up; a request that releases
// slots raises m_valid after passing the two-entry queue and the output register. The
// window update and the trailing-ones count on the 32-bit mark vector are combinational
// and are registered once per request. Reset is synchronous and active low and needs no
// clearing pass. A stalled m_ side backs up the queue and then drops s_ready.

module selective_repeat_receive_window (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [srrw_pkg::LEN_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [srrw_pkg::SEQ_W-1:0]  s_seq_num,
    input  logic [srrw_pkg::CTL_W-1:0]  s_control,
    input  logic                        s_intact,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [srrw_pkg::SEQ_W-1:0]  m_ack_seq,
    output logic [srrw_pkg::CTL_W-1:0]  m_ack_control,
    output logic [srrw_pkg::LEN_W-1:0]  m_released
);

    srrw_pkg::pkt_t q_pkt;
    logic           q_valid;
    logic           q_pop;

    srrw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_seq_num (s_seq_num),
        .s_control (s_control),
        .s_intact  (s_intact),
        .q_pkt     (q_pkt),
        .q_valid   (q_valid),
        .q_pop     (q_pop)
    );

    srrw_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_pkt         (q_pkt),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ack_seq     (m_ack_seq),
        .m_ack_control (m_ack_control),
        .m_released    (m_released)
    );

endmodule

>>> bench/selective_repeat_receive_window_test.sv
`timescale 1ns / 1ps

module selective_repeat_receive_window_test;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 7;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int QUIET_LIMIT = 4000;
    localparam int ACK_SLOTS = 64;

    typedef struct packed {
        logic [srrw_pkg::SEQ_W-1:0] seq;
        logic [srrw_pkg::CTL_W-1:0] ctl;
        logic [srrw_pkg::LEN_W-1:0] rel;
    } ack_t;

    class window_scoreboard;
        logic [srrw_pkg::SEQ_W-1:0] base;
        srrw_pkg::marks_t           marks;
        logic [srrw_pkg::CTL_W-1:0] flags [srrw_pkg::MAX_WINDOW];
        logic [srrw_pkg::LEN_W-1:0] wlen;
        ack_t                       acks_due [ACK_SLOTS];
        int                         ack_head;
        int                         ack_tail;
        int                         ack_count;
        int                         errors;

        function new();
            base = '0;
            marks = '0;
            wlen = srrw_pkg::LEN_RESET;
            foreach (flags[i]) flags[i] = '0;
            ack_head = 0;
            ack_tail = 0;
            ack_count = 0;
            errors = 0;
        endfunction

        function int eff_length();
            int l;
            l = wlen;
            if (l < 1) l = 1;
            if (l > srrw_pkg::MAX_WINDOW) l = srrw_pkg::MAX_WINDOW;
            return l;
        endfunction

        function int pending();
            return ack_count;
        endfunction

        function void set_window_length(logic [srrw_pkg::LEN_W-1:0] value);
            wlen = value;
            marks &= srrw_pkg::marks_t'((64'd1 << eff_length()) - 64'd1);
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task note_request(logic [srrw_pkg::SEQ_W-1:0] seq, logic [srrw_pkg::CTL_W-1:0] ctl,
                          logic ok);
            logic [srrw_pkg::SEQ_W-1:0] off;
            int                         run;
            ack_t                       a;
            if (!ok) return;
            off = seq - base;
            if (off < eff_length() && !marks[off[srrw_pkg::SLOT_W-1:0]]) begin
                marks[off[srrw_pkg::SLOT_W-1:0]] = 1'b1;
                flags[off[srrw_pkg::SLOT_W-1:0]] = ctl;
            end
            if (!marks[0]) return;
            run = 0;
            while (run < srrw_pkg::MAX_WINDOW && marks[run]) run++;
            a.seq = base + srrw_pkg::SEQ_W'(run - 1);
            a.ctl = flags[run - 1];
            a.rel = srrw_pkg::LEN_W'(run);
            if (ack_count == ACK_SLOTS) begin
                report("too many acknowledgements outstanding");
            end else begin
                acks_due[ack_tail] = a;
                ack_tail = (ack_tail + 1) % ACK_SLOTS;
                ack_count++;
            end
            marks = (run == srrw_pkg::MAX_WINDOW) ? '0 : marks >> run;
            for (int i = 0; i < srrw_pkg::MAX_WINDOW; i++) begin
                flags[i] = (i + run < srrw_pkg::MAX_WINDOW) ? flags[i + run] : '0;
            end
            base = base + srrw_pkg::SEQ_W'(run);
        endtask

        task check_ack(logic [srrw_pkg::SEQ_W-1:0] seq, logic [srrw_pkg::CTL_W-1:0] ctl,
                       logic [srrw_pkg::LEN_W-1:0] rel);
            ack_t a;
            if (ack_count == 0) begin
                report($sformatf("unexpected acknowledgement seq %0d", seq));
            end else begin
                a = acks_due[ack_head];
                ack_head = (ack_head + 1) % ACK_SLOTS;
                ack_count--;
                if (seq !== a.seq)
                    report($sformatf("ack_seq %0d, expected %0d", seq, a.seq));
                if (ctl !== a.ctl)
                    report($sformatf("ack_control %0h, expected %0h", ctl, a.ctl));
                if (rel !== a.rel)
                    report($sformatf("released %0d, expected %0d", rel, a.rel));
            end
        endtask
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [srrw_pkg::LEN_W-1:0] cfg_wr_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [srrw_pkg::SEQ_W-1:0] s_seq_num = '0;
    logic [srrw_pkg::CTL_W-1:0] s_control = '0;
    logic                       s_intact = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [srrw_pkg::SEQ_W-1:0] m_ack_seq;
    logic [srrw_pkg::CTL_W-1:0] m_ack_control;
    logic [srrw_pkg::LEN_W-1:0] m_released;

    window_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_taken = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    selective_repeat_receive_window dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_seq_num     (s_seq_num),
        .s_control     (s_control),
        .s_intact      (s_intact),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ack_seq     (m_ack_seq),
        .m_ack_control (m_ack_control),
        .m_released    (m_released)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    always @(negedge aclk) begin
        if (hold_left == 0 && holds_taken != hold_requests) begin
            holds_taken++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_ack(m_ack_seq, m_ack_control, m_released);
        end
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_request(input logic [srrw_pkg::SEQ_W-1:0] seq,
                                input logic [srrw_pkg::CTL_W-1:0] ctl, input logic ok);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_seq_num <= seq;
        s_control <= ctl;
        s_intact <= ok;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(seq, ctl, ok);
    endtask

    task automatic drain_acks();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_window_length(input logic [srrw_pkg::LEN_W-1:0] len);
        drain_acks();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        sb.set_window_length(len);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [srrw_pkg::LEN_W-1:0] len, input int send_pct,
                             input int recv_pct, input int items, input bit pressure);
        int                         taken;
        int                         l;
        int                         n;
        int                         pick;
        int                         tmp;
        int                         kind;
        bit                         held;
        bit                         paused;
        logic [srrw_pkg::SEQ_W-1:0] first;
        int                         order [srrw_pkg::MAX_WINDOW];
        write_window_length(len);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        taken = 0;
        held = 1'b0;
        paused = 1'b0;
        while (taken < items) begin
            if (pressure && !held && taken >= 60) begin
                held = 1'b1;
                hold_requests++;
            end
            if (pressure && !paused && taken >= items / 2) begin
                paused = 1'b1;
                drain_acks();
            end
            l = sb.eff_length();
            kind = $urandom_range(99);
            if (kind < 70) begin
                // A shuffled run of consecutive numbers from the base, so that
                // releases of every length up to the whole window occur.
                n = $urandom_range(l, 1);
                first = sb.base;
                for (int i = 0; i < n; i++) order[i] = i;
                for (int i = n - 1; i > 0; i--) begin
                    pick = $urandom_range(i, 0);
                    tmp = order[i];
                    order[i] = order[pick];
                    order[pick] = tmp;
                end
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(19) == 0) begin
                        send_request(first + srrw_pkg::SEQ_W'(order[i]),
                                     srrw_pkg::CTL_W'($urandom), 1'b0);
                        taken++;
                    end
                    send_request(first + srrw_pkg::SEQ_W'(order[i]),
                                 srrw_pkg::CTL_W'($urandom), 1'b1);
                    taken++;
                end
            end else if (kind < 85) begin
                send_request(sb.base + srrw_pkg::SEQ_W'($urandom_range(l - 1, 0)),
                             srrw_pkg::CTL_W'($urandom), 1'b1);
                taken++;
            end else if (kind < 93) begin
                send_request(sb.base + srrw_pkg::SEQ_W'($urandom_range(127, l)),
                             srrw_pkg::CTL_W'($urandom), 1'b1);
                taken++;
            end else begin
                send_request(srrw_pkg::SEQ_W'($urandom), srrw_pkg::CTL_W'($urandom), 1'b0);
                taken++;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_window_length(srrw_pkg::LEN_W'(32));
        send_request(7'd0, 8'hFF, 1'b0);
        send_request(7'd1, 8'hA5, 1'b1);
        send_request(7'd1, 8'h11, 1'b1);
        send_request(7'd0, 8'h00, 1'b1);
        send_request(7'd1, 8'h80, 1'b1);
        send_request(7'd34, 8'h55, 1'b1);
        send_request(7'd33, 8'h7F, 1'b1);
        send_request(7'd2, 8'hFF, 1'b1);
        write_window_length(srrw_pkg::LEN_W'(1));
        send_request(7'd4, 8'h01, 1'b1);
        send_request(7'd3, 8'h02, 1'b1);
        write_window_length(srrw_pkg::LEN_W'(0));
        send_request(7'd4, 8'h03, 1'b1);
        send_request(7'd6, 8'h04, 1'b1);
        write_window_length(srrw_pkg::LEN_W'(63));
        send_request(7'd36, 8'hC3, 1'b1);
        send_request(7'd37, 8'h3C, 1'b1);
        send_request(7'd5, 8'h5A, 1'b1);
        send_request(7'd6, 8'h96, 1'b0);
        send_request(7'd127, 8'h00, 1'b1);

        run_phase(srrw_pkg::LEN_W'(32), 20, 79, 250, 1'b0);
        run_phase(srrw_pkg::LEN_W'(1), 20, 79, 150, 1'b0);
        run_phase(srrw_pkg::LEN_W'(0), 20, 79, 150, 1'b0);
        run_phase(srrw_pkg::LEN_W'(63), 79, 20, 300, 1'b0);
        run_phase(srrw_pkg::LEN_W'(7), 79, 20, 300, 1'b0);
        run_phase(srrw_pkg::LEN_W'(20), 0, 0, 300, 1'b0);
        run_phase(srrw_pkg::LEN_W'(32), 0, 0, 450, 1'b1);

        drain_acks();
        repeat (SETTLE_CYCLES * 2) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
src/srrw_pkg.sv
src/srrw_front.sv
src/srrw_back.sv
src/selective_repeat_receive_window.sv
bench/selective_repeat_receive_window_test.sv
